FILE: src/steer_mode_drive_mixer_top_macros.svh
// Assertion helpers shared by the mixer RTL.
`ifndef STEER_MODE_DRIVE_MIXER_TOP_MACROS_SVH
`define STEER_MODE_DRIVE_MIXER_TOP_MACROS_SVH

// Clocked assertion, switched off while the asynchronous reset is held.
`define SMDM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication form of the clocked assertion.
`define SMDM_ASSERT_IMP(label, ante, cons, msg) \
	`SMDM_ASSERT(label, (ante) |-> (cons), msg)

`endif

FILE: src/smdm_pkg.sv
`default_nettype none
package smdm_pkg;

	localparam int MODE_W = 3;
	localparam int CALC_W = 11;

	localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DIFF   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FRONT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SPOT_L = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SPOT_R = 3'd4;

	localparam logic signed [CALC_W-1:0] PWM_MAX = 11'sd100;
	localparam logic signed [CALC_W-1:0] PWM_MIN = -11'sd100;

	// Saturates a mixing value to the motor range and narrows it to the PWM width.
	function automatic logic signed [7:0] clamp_pwm(input logic signed [CALC_W-1:0] v);
		logic signed [CALC_W-1:0] c;
		begin
			if (v > PWM_MAX) begin
				c = PWM_MAX;
			end else if (v < PWM_MIN) begin
				c = PWM_MIN;
			end else begin
				c = v;
			end
			clamp_pwm = c[7:0];
		end
	endfunction

endpackage
`default_nettype wire

FILE: src/steer_mode_drive_mixer_top.sv
// A word accepted into the input register passes through the result register before it is offered on the master side.
// One word per cycle while m_tready is held high; the input and result registers form a two-stage pipeline.
// The only stall is a held-off m_tready, which backs up through both stages.
// Reset (arst_n low, asynchronous) empties both stages and puts the steering mode in idle.
`default_nettype none
`include "steer_mode_drive_mixer_top_macros.svh"
module steer_mode_drive_mixer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// forward_cmd [7:0], manual_turn [15:8], line_turn [23:16], front_angle [39:24]
	input  wire logic [39:0] s_tdata,
	// drive_mode_req [0], steer_mode_req [3:1]
	input  wire logic [3:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// steer_angle [8:0], left_pwm [16:9], right_pwm [24:17], zeros above
	output logic [31:0]      m_tdata
);
	import smdm_pkg::*;

	// Input stage.
	logic                     valid_s1;
	logic signed [7:0]        forward_cmd_s1;
	logic signed [7:0]        manual_turn_s1;
	logic signed [7:0]        line_turn_s1;
	logic                     drive_mode_req_s1;
	logic        [MODE_W-1:0] steer_mode_req_s1;
	logic signed [15:0]       front_angle_s1;

	// Result stage.
	logic                     valid_s2;
	logic        [MODE_W-1:0] mode_s2;
	logic signed [8:0]        steer_angle_s2;
	logic signed [7:0]        left_pwm_s2;
	logic signed [7:0]        right_pwm_s2;

	logic        [MODE_W-1:0] mode_q;
	logic        [MODE_W-1:0] mode_d;

	logic adv_s2;
	logic adv_s1;

	logic signed [CALC_W-1:0] f_w;
	logic signed [CALC_W-1:0] t_w;
	logic signed [CALC_W-1:0] l_w;
	logic signed [CALC_W-1:0] r_w;
	logic signed [CALC_W-1:0] ang_w;
	logic signed [8:0]        steer_angle_d;
	logic signed [7:0]        left_pwm_d;
	logic signed [7:0]        right_pwm_d;
	logic                     centred;
	logic                     req_spot;

	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			forward_cmd_s1    <= s_tdata[7:0];
			manual_turn_s1    <= s_tdata[15:8];
			line_turn_s1      <= s_tdata[23:16];
			front_angle_s1    <= s_tdata[39:24];
			drive_mode_req_s1 <= s_tuser[0];
			steer_mode_req_s1 <= s_tuser[3:1];
		end
	end

	// Steering mode update. Leaving idle needs a centred wheel; the spot modes may swap freely.
	assign centred  = (front_angle_s1 == 16'sd0);
	assign req_spot = (steer_mode_req_s1 == MODE_SPOT_L) || (steer_mode_req_s1 == MODE_SPOT_R);

	always_comb begin
		mode_d = MODE_IDLE;
		case (mode_q)
			MODE_IDLE: begin
				if (centred && (steer_mode_req_s1 >= MODE_DIFF)
						&& (steer_mode_req_s1 <= MODE_SPOT_R)) begin
					mode_d = steer_mode_req_s1;
				end
			end
			MODE_SPOT_L, MODE_SPOT_R: begin
				if (req_spot) begin
					mode_d = steer_mode_req_s1;
				end
			end
			default: begin
				if (steer_mode_req_s1 == mode_q) begin
					mode_d = mode_q;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
		end else if (adv_s1) begin
			mode_q <= mode_d;
		end
	end

	// Output computation for the mode just chosen.
	always_comb begin
		f_w = {{(CALC_W-8){forward_cmd_s1[7]}}, forward_cmd_s1};
		if (drive_mode_req_s1) begin
			t_w = {{(CALC_W-8){line_turn_s1[7]}}, line_turn_s1};
		end else begin
			t_w = {{(CALC_W-8){manual_turn_s1[7]}}, manual_turn_s1};
		end
		ang_w       = '0;
		left_pwm_d  = forward_cmd_s1;
		right_pwm_d = forward_cmd_s1;
		l_w         = f_w + t_w;
		r_w         = f_w - t_w;
		case (mode_d)
			MODE_DIFF: begin
				// Excess over full scale on one wheel is taken off the other when moving forward.
				if (l_w > PWM_MAX) begin
					if (f_w > 0) begin
						r_w = r_w - (l_w - PWM_MAX);
					end
					l_w = PWM_MAX;
				end else if (l_w < PWM_MIN) begin
					l_w = PWM_MIN;
				end
				if (r_w > PWM_MAX) begin
					if (f_w > 0) begin
						l_w = l_w - (r_w - PWM_MAX);
					end
					r_w = PWM_MAX;
				end else if (r_w < PWM_MIN) begin
					r_w = PWM_MIN;
				end
				if (f_w > 0) begin
					if (l_w < 0) begin
						l_w = '0;
					end
					if (r_w < 0) begin
						r_w = '0;
					end
				end
				left_pwm_d  = l_w[7:0];
				right_pwm_d = r_w[7:0];
			end
			MODE_FRONT: begin
				ang_w = t_w;
			end
			MODE_SPOT_L: begin
				ang_w       = (t_w >= 0) ? -t_w : t_w;
				left_pwm_d  = clamp_pwm(-f_w);
				right_pwm_d = clamp_pwm(f_w);
			end
			MODE_SPOT_R: begin
				ang_w       = (t_w < 0) ? -t_w : t_w;
				left_pwm_d  = clamp_pwm(f_w);
				right_pwm_d = clamp_pwm(-f_w);
			end
			default: begin
			end
		endcase
		steer_angle_d = ang_w[8:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			mode_s2        <= mode_d;
			steer_angle_s2 <= steer_angle_d;
			left_pwm_s2    <= left_pwm_d;
			right_pwm_s2   <= right_pwm_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, right_pwm_s2, left_pwm_s2, steer_angle_s2};

	`SMDM_ASSERT_IMP(a_mode_moves_on_item, !$stable(mode_q), $past(adv_s1),
		"Steering mode changed without an item passing the input stage")
	`SMDM_ASSERT_IMP(a_leave_idle_centred, (mode_q != MODE_IDLE) && ($past(mode_q) == MODE_IDLE),
		$past(adv_s1) && ($past(front_angle_s1) == 16'sd0),
		"Steering mode left idle with the front wheel off centre")
	`SMDM_ASSERT_IMP(a_spot_opposed,
		valid_s2 && ((mode_s2 == MODE_SPOT_L) || (mode_s2 == MODE_SPOT_R)),
		left_pwm_s2 == -right_pwm_s2, "Spot turn wheels not driven in opposition")
	`SMDM_ASSERT_IMP(a_diff_in_range, valid_s2 && (mode_s2 == MODE_DIFF),
		(left_pwm_s2 <= 8'sd100) && (left_pwm_s2 >= -8'sd100)
		&& (right_pwm_s2 <= 8'sd100) && (right_pwm_s2 >= -8'sd100),
		"Differential drive word outside the motor range")

endmodule
`default_nettype wire

FILE: tb/drive_mix_checker.sv
import smdm_pkg::*;

module drive_mix_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// forward_cmd [7:0], manual_turn [15:8], line_turn [23:16], front_angle [39:24]
	input  logic [39:0] s_tdata,
	// drive_mode_req [0], steer_mode_req [3:1]
	input  logic [3:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// steer_angle [8:0], left_pwm [16:9], right_pwm [24:17], zeros above
	input  logic [31:0] m_tdata,
	output int          pending,
	output int          mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PWM_LIMIT = 100;

	typedef struct packed {
		logic signed [8:0] angle;
		logic signed [7:0] left;
		logic signed [7:0] right;
	} drive_cmd_t;

	logic [MODE_W-1:0] steer_state;
	drive_cmd_t        drive_cmd_q[$];

	function automatic int sat_pwm(input int v);
		if (v > PWM_LIMIT) begin
			return PWM_LIMIT;
		end else if (v < -PWM_LIMIT) begin
			return -PWM_LIMIT;
		end
		return v;
	endfunction

	// Works out the drive command for one word and advances the steering state.
	function automatic drive_cmd_t predict_drive(input logic [39:0] d, input logic [3:0] u);
		int                fwd;
		int                turn;
		int                ang;
		int                l;
		int                r;
		logic [MODE_W-1:0] req;
		logic [MODE_W-1:0] nxt;
		logic              centred;
		drive_cmd_t        c;
		fwd = $signed(d[7:0]);
		turn = u[0] ? $signed(d[23:16]) : $signed(d[15:8]);
		req = u[3:1];
		centred = (d[39:24] == 16'd0);
		case (steer_state)
			MODE_IDLE: begin
				nxt = (centred && req >= MODE_DIFF && req <= MODE_SPOT_R) ? req : MODE_IDLE;
			end
			MODE_SPOT_L, MODE_SPOT_R: begin
				nxt = (req == MODE_SPOT_L || req == MODE_SPOT_R) ? req : MODE_IDLE;
			end
			default: begin
				nxt = (req == steer_state) ? req : MODE_IDLE;
			end
		endcase
		steer_state = nxt;
		ang = 0;
		l = fwd;
		r = fwd;
		case (nxt)
			MODE_DIFF: begin
				l = fwd + turn;
				r = fwd - turn;
				// Excess on one wheel is taken off the other only while driving forward.
				if (l > PWM_LIMIT) begin
					if (fwd > 0) r -= l - PWM_LIMIT;
					l = PWM_LIMIT;
				end else if (l < -PWM_LIMIT) begin
					l = -PWM_LIMIT;
				end
				if (r > PWM_LIMIT) begin
					if (fwd > 0) l -= r - PWM_LIMIT;
					r = PWM_LIMIT;
				end else if (r < -PWM_LIMIT) begin
					r = -PWM_LIMIT;
				end
				if (fwd > 0) begin
					if (l < 0) l = 0;
					if (r < 0) r = 0;
				end
			end
			MODE_FRONT: begin
				ang = turn;
			end
			MODE_SPOT_L: begin
				ang = (turn >= 0) ? -turn : turn;
				l = sat_pwm(-fwd);
				r = sat_pwm(fwd);
			end
			MODE_SPOT_R: begin
				ang = (turn < 0) ? -turn : turn;
				l = sat_pwm(fwd);
				r = sat_pwm(-fwd);
			end
			default: begin
			end
		endcase
		c.angle = ang[8:0];
		c.left = l[7:0];
		c.right = r[7:0];
		return c;
	endfunction

	task automatic report(input string field, input int got, input int want);
		$display("%0t ns: %s is %0d, expected %0d", $time, field, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		drive_cmd_t want;
		if (!arst_n) begin
			steer_state = MODE_IDLE;
			drive_cmd_q.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (drive_cmd_q.size() == 0) begin
					report("word with nothing pending, steer_angle", $signed(m_tdata[8:0]), 0);
				end else begin
					want = drive_cmd_q.pop_front();
					if (m_tdata[8:0] !== want.angle)
						report("steer_angle", $signed(m_tdata[8:0]), want.angle);
					if (m_tdata[16:9] !== want.left)
						report("left_pwm", $signed(m_tdata[16:9]), want.left);
					if (m_tdata[24:17] !== want.right)
						report("right_pwm", $signed(m_tdata[24:17]), want.right);
					if (m_tdata[31:25] !== '0)
						report("padding", m_tdata[31:25], 0);
				end
			end
			if (s_tvalid && s_tready)
				drive_cmd_q.push_back(predict_drive(s_tdata, s_tuser));
			pending <= drive_cmd_q.size();
		end
	end

endmodule

FILE: tb/tb.sv
import smdm_pkg::*;

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOTAL_WORDS = 620;
	localparam int CYCLE_LIMIT = 200000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [3:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	int          pending;
	int          mismatches;
	int          sent = 0;
	int          cycles = 0;
	bit          full_rate = 1'b0;
	bit          hold_off_req = 1'b0;

	steer_mode_drive_mixer_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	drive_mix_checker mix_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.pending    (pending),
		.mismatches (mismatches)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) return 0;
		if (pick < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	function automatic int pick_byte();
		case ($urandom_range(0, 7))
			0: return -128;
			1: return 127;
			2: return 0;
			3: return $urandom_range(95, 105) * ($urandom_range(0, 1) ? 1 : -1);
			default: return $urandom_range(0, 255) - 128;
		endcase
	endfunction

	// Receiver side: random back-pressure, plus one long hold-off on request.
	initial begin
		bit rdy;
		int len;
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				rdy = 1'b0;
				len = 60;
			end else if (full_rate) begin
				rdy = 1'b1;
				len = 1;
			end else begin
				rdy = ($urandom_range(0, 3) != 0);
				len = rdy ? $urandom_range(1, 8) : idle_len() + 1;
			end
			m_tready <= rdy;
			repeat (len) @(posedge clk);
		end
	end

	task automatic send_word(input int fwd, input int man, input int line, input bit dsel,
			input int req, input int ang);
		int gap;
		s_tdata <= {ang[15:0], line[7:0], man[7:0], fwd[7:0]};
		s_tuser <= {req[2:0], dsel};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
		gap = full_rate ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// The pending count is registered behind the handshake, hence the first wait.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int  req;
		int  ang;
		int  len;
		bit  noise;
		bit  held;
		bit  drained;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		held = 1'b0;
		drained = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Leaving idle needs a centred wheel.
		send_word(127, 5, 9, 1'b0, MODE_DIFF, 1);
		send_word(60, 60, 0, 1'b0, MODE_DIFF, 0);
		send_word(127, -128, 0, 1'b0, MODE_DIFF, 0);
		send_word(-128, 0, 127, 1'b1, MODE_DIFF, 16'h8000);
		send_word(0, 127, 0, 1'b0, MODE_DIFF, 0);
		send_word(1, -1, 0, 1'b0, MODE_DIFF, 0);
		// A changed request drops to idle in the same tick.
		send_word(-128, 3, 3, 1'b0, MODE_FRONT, 0);
		send_word(-7, -128, 0, 1'b0, MODE_FRONT, 0);
		send_word(100, 0, 127, 1'b1, MODE_FRONT, 16'h7fff);
		send_word(-100, 0, 0, 1'b0, MODE_SPOT_L, 0);
		send_word(-128, -128, 0, 1'b0, MODE_SPOT_L, 0);
		send_word(127, 0, -128, 1'b1, MODE_SPOT_R, 16'hffff);
		send_word(0, 127, 0, 1'b0, MODE_SPOT_L, 0);
		send_word(101, 0, 0, 1'b0, MODE_SPOT_R, 0);
		// Unused request codes behave as an idle request.
		send_word(-128, 0, 0, 1'b0, 5, 0);
		send_word(127, 0, 0, 1'b1, 7, 0);
		send_word(-1, 0, 0, 1'b0, 6, 0);
		send_word(50, 0, 0, 1'b0, MODE_IDLE, 0);
		send_word(20, 20, 20, 1'b1, MODE_SPOT_R, 16'h8000);
		send_word(-60, 0, -70, 1'b1, MODE_DIFF, 0);
		send_word(-60, 0, 90, 1'b1, MODE_DIFF, 16'h0001);

		while (sent < TOTAL_WORDS) begin
			noise = ($urandom_range(0, 6) == 0);
			req = $urandom_range(MODE_DIFF, MODE_SPOT_R);
			len = $urandom_range(1, 16);
			for (int i = 0; i < len; i++) begin
				if (noise) begin
					req = $urandom_range(0, 7);
					ang = $urandom_range(0, 1) ? 0 : $urandom_range(0, 65535);
				end else begin
					if (i == 0) begin
						ang = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 65535) : 0;
					end else begin
						ang = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535);
					end
					if (req >= MODE_SPOT_L && i > 0 && $urandom_range(0, 5) == 0)
						req = (req == MODE_SPOT_L) ? MODE_SPOT_R : MODE_SPOT_L;
				end
				send_word(pick_byte(), pick_byte(), pick_byte(), 1'($urandom_range(0, 1)),
					req, ang);
				if (sent >= 150 && !held) begin
					held = 1'b1;
					hold_off_req = 1'b1;
				end
				if (sent >= 260 && !drained) begin
					drained = 1'b1;
					drain();
				end
				full_rate = (sent >= 300 && sent < 380);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
